// ===== hdl/salc_pkg.sv =====
// ============================================================================
// salc_pkg: shared types and constants of the LRU cache lookup
// Configuration widths, register indexes, outcome codes and the command
// bundle that the sequencer sends to the line store.
// ============================================================================
package salc_pkg;

    // default geometry
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_WAYS         = 4;
    localparam int DEF_ADDR_WIDTH   = 64;

    // port widths fixed by the item formats
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;
    localparam int OUTCOME_W  = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_CFG_W   = 3;
    localparam int OB_CFG_W   = 6;
    localparam int WAYS_CFG_W = 3;
    localparam int SB_W       = 4;   // holds a set bit count up to 15
    localparam int SHAMT_W    = 7;   // set bits plus offset bits

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [SB_CFG_W-1:0]   RST_SET_BITS    = 3'd4;
    localparam logic [OB_CFG_W-1:0]   RST_OFFSET_BITS = 6'd4;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 3'd4;
    localparam logic [OB_CFG_W-1:0]   MAX_OFFSET_BITS = 6'd32;

    // lookup outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    // sequencer to line store
    typedef struct packed {
        logic rd_en;      // read tag, rank and valid of one line
        logic rank_we;    // write the rank of one line
        logic line_we;    // write the tag of one line and mark it valid
        logic clear_all;  // drop every valid bit
    } t_store_cmd;

endpackage

// ===== hdl/salc_store.sv =====
// ============================================================================
// salc_store: line store of the cache lookup
// Tag and rank memories with registered read, plus one valid flop per line
// that reset and a configuration write clear at once.
// ============================================================================
module salc_store #(
    parameter int LINES  = 256,
    parameter int LINE_W = 8,
    parameter int TAG_W  = 64,
    parameter int RANK_W = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  salc_pkg::t_store_cmd i_cmd,
    input  logic [LINE_W-1:0]    i_line_addr,
    input  logic [TAG_W-1:0]     i_wr_tag,
    input  logic [RANK_W-1:0]    i_wr_rank,
    output logic                 o_rd_valid,
    output logic [TAG_W-1:0]     o_rd_tag,
    output logic [RANK_W-1:0]    o_rd_rank
);
    import salc_pkg::*;

    logic [TAG_W-1:0]  tag_mem  [LINES];
    logic [RANK_W-1:0] rank_mem [LINES];
    logic [LINES-1:0]  r_valid;
    logic              r_rd_valid;
    logic [TAG_W-1:0]  r_rd_tag;
    logic [RANK_W-1:0] r_rd_rank;

    // valid bits: clear on reset or configuration, set on a line write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.line_we) begin
            r_valid[i_line_addr] <= 1'b1;
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.line_we) begin
            tag_mem[i_line_addr] <= i_wr_tag;
        end
        if (i_cmd.rank_we) begin
            rank_mem[i_line_addr] <= i_wr_rank;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_tag   <= tag_mem[i_line_addr];
            r_rd_rank  <= rank_mem[i_line_addr];
            r_rd_valid <= r_valid[i_line_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_tag   = r_rd_tag;
    assign o_rd_rank  = r_rd_rank;

endmodule

// ===== hdl/salc_seq.sv =====
// ============================================================================
// salc_seq: lookup sequencer of the cache lookup
// Holds the configuration, splits the address, walks the ways of one set
// through a single tag and rank compare unit, then walks them again to
// write the updated ranks and the new line. Drives the result register.
// ============================================================================
module salc_seq #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS         = 4,
    parameter int ADDR_WIDTH   = 64,
    parameter int SET_W        = 6,
    parameter int LINE_W       = 8,
    parameter int RANK_W       = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic [salc_pkg::IN_DATA_W-1:0]      i_s_addr,
    // result items
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic [salc_pkg::OUTCOME_W-1:0]      o_m_outcome,
    // line store
    output salc_pkg::t_store_cmd                o_cmd,
    output logic [LINE_W-1:0]                   o_line_addr,
    output logic [ADDR_WIDTH-1:0]               o_wr_tag,
    output logic [RANK_W-1:0]                   o_wr_rank,
    input  logic                                i_rd_valid,
    input  logic [ADDR_WIDTH-1:0]               i_rd_tag,
    input  logic [RANK_W-1:0]                   i_rd_rank
);
    import salc_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(WAYS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [SB_CFG_W-1:0]   r_cfg_sb;
    logic [OB_CFG_W-1:0]   r_cfg_ob;
    logic [WAYS_CFG_W-1:0] r_cfg_ways;
    logic                  cfg_hit;

    // item context
    logic [ADDR_WIDTH-1:0] r_tag, n_tag;
    logic [LINE_W-1:0]     r_base, n_base;
    logic [CNT_W-1:0]      r_nways, n_nways;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pend, n_pend;
    logic [WAY_W-1:0]      r_pend_way, n_pend_way;

    // scan accumulators
    logic                  r_hit, n_hit;
    logic [WAY_W-1:0]      r_hit_way, n_hit_way;
    logic [RANK_W-1:0]     r_hit_rank, n_hit_rank;
    logic                  r_inv, n_inv;
    logic [WAY_W-1:0]      r_inv_way, n_inv_way;
    logic [CNT_W-1:0]      r_nvalid, n_nvalid;
    logic [WAY_W-1:0]      r_vic_way, n_vic_way;
    logic [RANK_W-1:0]     r_vic_rank, n_vic_rank;
    logic [RANK_W-1:0]     r_rank_buf [WAYS];
    logic [WAYS-1:0]       r_vbuf;

    // decision
    logic [WAY_W-1:0]      r_target, n_target;
    logic [CNT_W-1:0]      r_old, n_old;
    t_outcome              r_outcome, n_outcome;

    // result register
    logic                  r_out_valid, n_out_valid;
    t_outcome              r_out_data, n_out_data;

    // address split
    logic [SB_W-1:0]       sb;
    logic [OB_CFG_W-1:0]   ob;
    logic [ADDR_WIDTH-1:0] addr_m;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W-1:0]      idx_keep;
    logic [SET_W-1:0]      set_idx;
    logic [SHAMT_W-1:0]    tag_shamt;
    logic [CNT_W-1:0]      nways_eff;

    // update datapath
    logic [WAY_W-1:0]      cur_way;
    logic [RANK_W-1:0]     cur_rank;
    logic                  cur_valid;
    logic                  is_target;
    logic                  proc_cap;

    // configuration registers: to be written only while idle, a rule on the user that the block does not enforce
    always_comb begin
        cfg_hit = 1'b0;
        case (i_cfg_index)
            CFG_SET_BITS, CFG_OFFSET_BITS, CFG_WAYS_IN_USE: cfg_hit = i_cfg_we;
            default:                                        cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sb   <= RST_SET_BITS;
            r_cfg_ob   <= RST_OFFSET_BITS;
            r_cfg_ways <= RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS:    r_cfg_sb   <= i_cfg_data[SB_CFG_W-1:0];
                CFG_OFFSET_BITS: r_cfg_ob   <= i_cfg_data[OB_CFG_W-1:0];
                CFG_WAYS_IN_USE: r_cfg_ways <= i_cfg_data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp configuration and split the incoming address
    always_comb begin
        if (32'(r_cfg_sb) > MAX_SET_BITS) sb = SB_W'(MAX_SET_BITS);
        else                              sb = SB_W'(r_cfg_sb);
        if (r_cfg_ob > MAX_OFFSET_BITS)   ob = MAX_OFFSET_BITS;
        else                              ob = r_cfg_ob;
        if (r_cfg_ways == '0)             nways_eff = CNT_W'(1);
        else if (32'(r_cfg_ways) > WAYS)  nways_eff = CNT_W'(WAYS);
        else                              nways_eff = CNT_W'(r_cfg_ways);

        addr_m    = i_s_addr[ADDR_WIDTH-1:0];
        addr_sh   = addr_m >> ob;
        idx_keep  = ~({SET_W{1'b1}} << sb);
        set_idx   = addr_sh[SET_W-1:0] & idx_keep;
        tag_shamt = SHAMT_W'(sb) + SHAMT_W'(ob);
    end

    // update walk: new rank of the current way
    always_comb begin
        cur_way   = r_cnt[WAY_W-1:0];
        cur_rank  = r_rank_buf[cur_way];
        cur_valid = r_vbuf[cur_way];
        is_target = (cur_way == r_target);
        if (is_target) begin
            o_wr_rank = '0;
        end else if (cur_valid && (CNT_W'(cur_rank) < r_old)) begin
            o_wr_rank = RANK_W'(cur_rank + 1'b1);
        end else begin
            o_wr_rank = cur_rank;
        end
    end

    assign o_line_addr = r_base + LINE_W'(r_cnt[WAY_W-1:0]);
    assign o_wr_tag    = r_tag;
    assign o_s_ready   = (r_state == S_IDLE);
    assign o_m_valid   = r_out_valid;
    assign o_m_outcome = r_out_data;
    assign proc_cap    = (r_state == S_SCAN) && r_pend;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_base      = r_base;
        n_nways     = r_nways;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pend_way  = r_pend_way;
        n_hit       = r_hit;
        n_hit_way   = r_hit_way;
        n_hit_rank  = r_hit_rank;
        n_inv       = r_inv;
        n_inv_way   = r_inv_way;
        n_nvalid    = r_nvalid;
        n_vic_way   = r_vic_way;
        n_vic_rank  = r_vic_rank;
        n_target    = r_target;
        n_old       = r_old;
        n_outcome   = r_outcome;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out_data  = r_out_data;
        o_cmd       = '0;
        o_cmd.clear_all = cfg_hit;

        case (r_state)
            S_IDLE: begin
                // take an item and reset the walk
                if (i_s_valid) begin
                    n_tag    = addr_m >> tag_shamt;
                    n_base   = LINE_W'(LINE_W'(set_idx) * LINE_W'(WAYS));
                    n_nways  = nways_eff;
                    n_cnt    = '0;
                    n_hit    = 1'b0;
                    n_inv    = 1'b0;
                    n_nvalid = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next way read
                if (r_cnt != r_nways) begin
                    o_cmd.rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_way  = r_cnt[WAY_W-1:0];
                    n_cnt       = r_cnt + 1'b1;
                end else if (!r_pend) begin
                    n_state = S_DECIDE;
                end
                // compare the way read last cycle
                if (r_pend) begin
                    if (i_rd_valid && (i_rd_tag == r_tag) && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_way  = r_pend_way;
                        n_hit_rank = i_rd_rank;
                    end
                    if (!i_rd_valid && !r_inv) begin
                        n_inv     = 1'b1;
                        n_inv_way = r_pend_way;
                    end
                    if (i_rd_valid) begin
                        n_nvalid = r_nvalid + 1'b1;
                    end
                    if ((r_pend_way == '0) || (i_rd_rank > r_vic_rank)) begin
                        n_vic_way  = r_pend_way;
                        n_vic_rank = i_rd_rank;
                    end
                end
            end
            S_DECIDE: begin
                // pick the way to touch and its former rank
                if (r_hit) begin
                    n_target  = r_hit_way;
                    n_old     = CNT_W'(r_hit_rank);
                    n_outcome = OUT_HIT;
                end else if (r_inv) begin
                    n_target  = r_inv_way;
                    n_old     = r_nvalid;
                    n_outcome = OUT_FILL;
                end else begin
                    n_target  = r_vic_way;
                    n_old     = CNT_W'(r_vic_rank);
                    n_outcome = OUT_EVICT;
                end
                n_cnt   = '0;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // write back one way per cycle
                o_cmd.rank_we = is_target || cur_valid;
                o_cmd.line_we = is_target && (r_outcome != OUT_HIT);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == r_nways - 1'b1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hand over the result once the output register is free
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_outcome;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and walk state
    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_base     <= n_base;
        r_nways    <= n_nways;
        r_cnt      <= n_cnt;
        r_pend_way <= n_pend_way;
        r_hit      <= n_hit;
        r_hit_way  <= n_hit_way;
        r_hit_rank <= n_hit_rank;
        r_inv      <= n_inv;
        r_inv_way  <= n_inv_way;
        r_nvalid   <= n_nvalid;
        r_vic_way  <= n_vic_way;
        r_vic_rank <= n_vic_rank;
        r_target   <= n_target;
        r_old      <= n_old;
        r_outcome  <= n_outcome;
        r_out_data <= n_out_data;
        if (proc_cap) begin
            r_rank_buf[r_pend_way] <= i_rd_rank;
            r_vbuf[r_pend_way]     <= i_rd_valid;
        end
    end

endmodule

// ===== hdl/set_assoc_lru_cache_lookup.sv =====
// ============================================================================
// set_assoc_lru_cache_lookup: set-associative tag lookup with LRU replacement
// Splits each address into set and tag, reports hit, fill or eviction, and
// keeps per-way recency ranks in a line store.
//
//   channel   direction  payload (lowest bit first)      handshake
//   s_axis    in         tdata: address [63:0]           tvalid/tready
//   m_axis    out        tdata: outcome [1:0], zeros     tvalid/tready
//   cfg       in         index, data [5:0]               write enable
//
// An item passes the states scan, decide, update and finish; the next one
// is taken in idle only after that: the sequencer reads the ways in use of
// the set one way a cycle through the registered tag/rank port, ending with
// the last compare and the read drain, decides, writes the set back one way
// a cycle and hands the result over once the result register is free.
// Reset clears the valid flops at once; no clearing pass is needed.
// A stalled output holds the item in the result register; the next item is
// taken meanwhile and waits only at its own hand-over.
// ============================================================================
module set_assoc_lru_cache_lookup #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int WAYS         = salc_pkg::DEF_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [salc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,   // address
    // result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [salc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata    // outcome, zero fill
);
    import salc_pkg::*;

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int LINES  = (1 << MAX_SET_BITS) * WAYS;
    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    t_store_cmd              cmd;
    logic [LINE_W-1:0]       line_addr;
    logic [ADDR_WIDTH-1:0]   wr_tag;
    logic [RANK_W-1:0]       wr_rank;
    logic                    rd_valid;
    logic [ADDR_WIDTH-1:0]   rd_tag;
    logic [RANK_W-1:0]       rd_rank;
    logic [OUTCOME_W-1:0]    outcome;

    salc_seq #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .WAYS         (WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .SET_W        (SET_W),
        .LINE_W       (LINE_W),
        .RANK_W       (RANK_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_addr    (i_s_axis_tdata),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_outcome (outcome),
        .o_cmd       (cmd),
        .o_line_addr (line_addr),
        .o_wr_tag    (wr_tag),
        .o_wr_rank   (wr_rank),
        .i_rd_valid  (rd_valid),
        .i_rd_tag    (rd_tag),
        .i_rd_rank   (rd_rank)
    );

    salc_store #(
        .LINES  (LINES),
        .LINE_W (LINE_W),
        .TAG_W  (ADDR_WIDTH),
        .RANK_W (RANK_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_line_addr (line_addr),
        .i_wr_tag    (wr_tag),
        .i_wr_rank   (wr_rank),
        .o_rd_valid  (rd_valid),
        .o_rd_tag    (rd_tag),
        .o_rd_rank   (rd_rank)
    );

    // pack the outcome into the low bits of the result bus
    assign o_m_axis_tdata = {{(OUT_DATA_W - OUTCOME_W){1'b0}}, outcome};

endmodule
